// ===== hdl/blt_pkg.sv =====
package blt_pkg;

	// Field widths
	localparam int OP_W     = 3;
	localparam int PID_W    = 22;
	localparam int OFS_W    = 32;
	localparam int STATUS_W = 2;

	// Default table size
	localparam int TABLE_DEPTH_DEF = 16;

	// Opcodes
	localparam logic [OP_W-1:0] OP_ADD     = 3'd0;
	localparam logic [OP_W-1:0] OP_UNLOCK  = 3'd1;
	localparam logic [OP_W-1:0] OP_HOLDS   = 3'd2;
	localparam logic [OP_W-1:0] OP_RELEASE = 3'd3;
	localparam logic [OP_W-1:0] OP_FIND    = 3'd4;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_CONFLICT = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;

	// Range end when the length is zero
	localparam logic [OFS_W-1:0] FULL_END = 32'hFFFF_FFFF;

	// One stored lock
	typedef struct packed {
		logic [OFS_W-1:0] start;
		logic [OFS_W-1:0] length;
		logic [PID_W-1:0] owner;
	} entry_t;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic scan;
		logic finish;
	} blt_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic scan_done;
	} blt_sts_t;

	// Inclusive end of a range, 33 bits so that it never wraps
	function automatic logic [OFS_W:0] end_of(input logic [OFS_W-1:0] start,
			input logic [OFS_W-1:0] length);
		logic [OFS_W:0] e;
		if (length == '0) begin
			e = {1'b0, FULL_END};
		end else begin
			e = {1'b0, start} + {1'b0, length};
		end
		return e;
	endfunction

endpackage

// ===== hdl/blt_chan_if.sv =====
// Request channel
interface blt_req_if;
	logic                       valid;
	logic                       ready;
	logic [blt_pkg::OP_W-1:0]   opcode;
	logic [blt_pkg::PID_W-1:0]  caller_pid;
	logic [blt_pkg::PID_W-1:0]  owner_pid;
	logic [blt_pkg::OFS_W-1:0]  range_start;
	logic [blt_pkg::OFS_W-1:0]  range_length;
	logic                       other_process;

	modport source(output valid, opcode, caller_pid, owner_pid, range_start, range_length,
		other_process, input ready);
	modport sink(input valid, opcode, caller_pid, owner_pid, range_start, range_length,
		other_process, output ready);
endinterface

// Response channel
interface blt_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [blt_pkg::STATUS_W-1:0]  status;
	logic                          hit;
	logic [blt_pkg::OFS_W-1:0]     match_start;
	logic [blt_pkg::OFS_W-1:0]     match_length;
	logic [blt_pkg::PID_W-1:0]     match_owner;

	modport source(output valid, status, hit, match_start, match_length, match_owner,
		input ready);
	modport sink(input valid, status, hit, match_start, match_length, match_owner,
		output ready);
endinterface

// ===== hdl/blt_ram.sv =====
module blt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hdl/blt_ctrl.sv =====
module blt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  blt_pkg::blt_sts_t sts,
	output blt_pkg::blt_cmd_t cmd
);
	import blt_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_DONE = 3'b100
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || out_ready;

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_done) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (slot_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== hdl/blt_dp.sv =====
module blt_dp #(
	parameter int DEPTH = blt_pkg::TABLE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  blt_pkg::blt_cmd_t             cmd,
	output blt_pkg::blt_sts_t             sts,
	output logic [$clog2(DEPTH+1)-1:0]    count,
	// request payload
	input  logic [blt_pkg::OP_W-1:0]      opcode,
	input  logic [blt_pkg::PID_W-1:0]     caller_pid,
	input  logic [blt_pkg::PID_W-1:0]     owner_pid,
	input  logic [blt_pkg::OFS_W-1:0]     range_start,
	input  logic [blt_pkg::OFS_W-1:0]     range_length,
	input  logic                          other_process,
	// response payload
	output logic [blt_pkg::STATUS_W-1:0]  status,
	output logic                          hit,
	output logic [blt_pkg::OFS_W-1:0]     match_start,
	output logic [blt_pkg::OFS_W-1:0]     match_length,
	output logic [blt_pkg::PID_W-1:0]     match_owner
);
	import blt_pkg::*;

	localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW      = $clog2(DEPTH+1);
	localparam int ENTRY_W = $bits(entry_t);

	// Request registers
	logic [OP_W-1:0]  op_q;
	logic [PID_W-1:0] caller_q;
	logic [PID_W-1:0] owner_q;
	logic [OFS_W-1:0] qs_q;
	logic [OFS_W:0]   qe_q;
	logic             other_q;
	entry_t           new_entry_q;

	// Scan state
	logic [CW-1:0] count_q;
	logic [CW-1:0] rd_q;
	logic [CW-1:0] wr_q;
	logic          vld_s1;
	logic          hit_q;
	logic          conflict_q;
	logic          found_q;
	entry_t        match_q;

	// Response registers
	logic [STATUS_W-1:0] status_q;
	logic                hit_out_q;
	entry_t              match_out_q;

	// Table memory
	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic [ENTRY_W-1:0] ram_rdata;
	entry_t             rd_entry;

	logic           issue;
	logic [OFS_W:0] e_start;
	logic [OFS_W:0] e_end;
	logic           ovl;
	logic           same_caller;
	logic           same_owner;
	logic           compact_op;
	logic           remove;
	logic           find_hit;
	logic           holds_hit;
	logic           add_conflict;
	logic           full;
	logic           add_ok;

	assign issue    = cmd.scan && (rd_q < count_q);
	assign rd_entry = ram_rdata;
	assign full     = (count_q == CW'(DEPTH));

	// Overlap test on the entry coming out of memory
	assign e_start     = {1'b0, rd_entry.start};
	assign e_end       = end_of(rd_entry.start, rd_entry.length);
	assign ovl         = ((e_start >= {1'b0, qs_q}) && (e_start <= qe_q)) ||
	                     ((e_end >= {1'b0, qs_q}) && (e_end <= qe_q));
	assign same_caller = (rd_entry.owner == caller_q);
	assign same_owner  = (rd_entry.owner == owner_q);

	// Per-opcode decisions for one entry
	always_comb begin
		compact_op   = 1'b0;
		remove       = 1'b0;
		find_hit     = 1'b0;
		holds_hit    = 1'b0;
		add_conflict = 1'b0;
		unique case (op_q)
			OP_ADD: begin
				add_conflict = ovl && !same_caller;
			end
			OP_UNLOCK: begin
				compact_op = 1'b1;
				remove     = ovl && same_caller;
			end
			OP_HOLDS: begin
				holds_hit = same_owner;
			end
			OP_RELEASE: begin
				compact_op = 1'b1;
				remove     = same_owner;
			end
			OP_FIND: begin
				find_hit = ovl && (other_q ? !same_caller : same_caller);
			end
			default: begin
				compact_op = 1'b0;
			end
		endcase
	end

	assign add_ok = (op_q == OP_ADD) && !conflict_q && !full;

	// Write port: compaction during the scan, append at finish
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = wr_q[AW-1:0];
		ram_wdata = rd_entry;
		if (vld_s1 && compact_op && !remove) begin
			ram_we = 1'b1;
		end else if (cmd.finish && add_ok) begin
			ram_we    = 1'b1;
			ram_waddr = count_q[AW-1:0];
			ram_wdata = new_entry_q;
		end
	end

	blt_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (rd_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			rd_q       <= '0;
			wr_q       <= '0;
			vld_s1     <= 1'b0;
			hit_q      <= 1'b0;
			conflict_q <= 1'b0;
			found_q    <= 1'b0;
		end else begin
			vld_s1 <= issue;
			if (cmd.load) begin
				rd_q       <= '0;
				wr_q       <= '0;
				hit_q      <= 1'b0;
				conflict_q <= 1'b0;
				found_q    <= 1'b0;
			end else begin
				if (issue) begin
					rd_q <= rd_q + 1'b1;
				end
				if (vld_s1) begin
					if (compact_op && !remove) begin
						wr_q <= wr_q + 1'b1;
					end
					// release-all removes entries but reports no hit
					if (((op_q == OP_UNLOCK) && remove) || holds_hit || find_hit) begin
						hit_q <= 1'b1;
					end
					if (add_conflict) begin
						conflict_q <= 1'b1;
					end
					if (find_hit) begin
						found_q <= 1'b1;
					end
				end
			end
			// Commit the new entry count
			if (cmd.finish) begin
				if (add_ok) begin
					count_q <= count_q + 1'b1;
				end else if (compact_op) begin
					count_q <= wr_q;
				end
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q               <= opcode;
			caller_q           <= caller_pid;
			owner_q            <= owner_pid;
			other_q            <= other_process;
			qs_q               <= range_start;
			qe_q               <= end_of(range_start, range_length);
			new_entry_q.start  <= range_start;
			new_entry_q.length <= range_length;
			new_entry_q.owner  <= owner_pid;
			match_q            <= '0;
		end else if (vld_s1 && find_hit && !found_q) begin
			match_q <= rd_entry;
		end
		if (cmd.finish) begin
			if (op_q == OP_ADD) begin
				status_q <= conflict_q ? ST_CONFLICT : (full ? ST_FULL : ST_OK);
			end else begin
				status_q <= ST_OK;
			end
			hit_out_q   <= hit_q;
			match_out_q <= match_q;
		end
	end

	assign sts.scan_done = (rd_q == count_q) && !vld_s1;
	assign count         = count_q;
	assign status        = status_q;
	assign hit           = hit_out_q;
	assign match_start   = match_out_q.start;
	assign match_length  = match_out_q.length;
	assign match_owner   = match_out_q.owner;

endmodule

// ===== hdl/byte_range_lock_table_unit.sv =====
// Byte-range lock table: keeps up to TABLE_DEPTH locks (start, length, owner) in
// insertion order and serves add, unlock, holds-lock test, release-all and
// find-first requests, one at a time, with exactly one response per request.
// Every request walks the stored entries through the single read port of the
// table memory, one entry per cycle, compacting the table in the same pass when
// entries are removed. A response still waiting to be taken holds the next one
// back until it is taken. A length of zero means the range runs to 0xFFFFFFFF;
// for add, unlock and find, an entry matches when its start or its end lies
// within the request range.
module byte_range_lock_table_unit #(
	parameter int TABLE_DEPTH = blt_pkg::TABLE_DEPTH_DEF
) (
	input logic    clk,
	input logic    arst_n,
	blt_req_if.sink   req,
	blt_rsp_if.source rsp
);
	import blt_pkg::*;

	localparam int CW = $clog2(TABLE_DEPTH+1);

	blt_cmd_t      cmd;
	blt_sts_t      sts;
	logic [CW-1:0] count;

	// Sequencer
	blt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Table and compare logic
	blt_dp #(
		.DEPTH(TABLE_DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.count         (count),
		.opcode        (req.opcode),
		.caller_pid    (req.caller_pid),
		.owner_pid     (req.owner_pid),
		.range_start   (req.range_start),
		.range_length  (req.range_length),
		.other_process (req.other_process),
		.status        (rsp.status),
		.hit           (rsp.hit),
		.match_start   (rsp.match_start),
		.match_length  (rsp.match_length),
		.match_owner   (rsp.match_owner)
	);

	// Entry count never exceeds the table size
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count <= CW'(TABLE_DEPTH))
		else $error("entry count beyond table size");

	// Table size changes only when a transaction is committed
	a_count_commit: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.finish |=> $stable(count))
		else $error("entry count changed outside commit");

	// One transaction at a time: busy right after acceptance
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request accepted while busy");

	// Refused adds carry no hit and no match
	a_refused: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.status == ST_CONFLICT || rsp.status == ST_FULL)) |->
		(!rsp.hit && rsp.match_start == '0 && rsp.match_owner == '0))
		else $error("refused add reports a match");

endmodule

// ===== tb/sv/byte_range_lock_table_unit_test.sv =====
`timescale 1ns / 1ps

module byte_range_lock_table_unit_test;
	import blt_pkg::*;

	localparam int TBL_DEPTH    = TABLE_DEPTH_DEF;
	localparam int LIMIT_CYCLES = 400000;

	// Opcodes with no function; they must leave the table alone
	localparam logic [OP_W-1:0] OP_UNUSED_FIRST = 3'd5;
	localparam logic [OP_W-1:0] OP_UNUSED_LAST  = 3'd7;

	localparam logic [PID_W-1:0] PID_ALL_ONES = '1;

	typedef struct packed {
		logic [OP_W-1:0]  opcode;
		logic [PID_W-1:0] caller;
		logic [PID_W-1:0] owner;
		logic [OFS_W-1:0] start;
		logic [OFS_W-1:0] length;
		logic             other;
	} lock_req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                hit;
		logic [OFS_W-1:0]    start;
		logic [OFS_W-1:0]    length;
		logic [PID_W-1:0]    owner;
	} lock_rsp_t;

	logic clk;
	logic arst_n;

	blt_req_if req_ch();
	blt_rsp_if rsp_ch();

	byte_range_lock_table_unit #(
		.TABLE_DEPTH(TBL_DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	// Shadow copy of the lock table
	entry_t lock_tbl[TBL_DEPTH];
	int lock_cnt;

	lock_rsp_t pending_rsp[$];
	int mismatch_cnt;
	int cycle_cnt;
	int send_idle_pct;
	int recv_stall_pct;
	int hold_request;
	int hold_left;
	logic [PID_W-1:0] pid_pool[4];

	// Inclusive last byte, 33 bits wide
	function automatic logic [OFS_W:0] range_last(input logic [OFS_W-1:0] s,
			input logic [OFS_W-1:0] len);
		if (len == '0) begin
			return {1'b0, 32'hFFFF_FFFF};
		end
		return {1'b0, s} + {1'b0, len};
	endfunction

	// Start or end of the entry inside [q1, q2], owner filtered
	function automatic bit entry_hits(input int i, input logic [OFS_W:0] q1,
			input logic [OFS_W:0] q2, input bit other, input logic [PID_W-1:0] caller);
		logic [OFS_W:0] s1;
		logic [OFS_W:0] s2;
		bit overlap;
		bit same;
		s1 = {1'b0, lock_tbl[i].start};
		s2 = range_last(lock_tbl[i].start, lock_tbl[i].length);
		overlap = (s1 >= q1 && s1 <= q2) || (s2 >= q1 && s2 <= q2);
		same = (lock_tbl[i].owner == caller);
		return overlap && (other ? !same : same);
	endfunction

	// Remove one entry, keeping the order of the rest
	function automatic void drop_entry(input int i);
		for (int j = i; j + 1 < lock_cnt; j++) begin
			lock_tbl[j] = lock_tbl[j + 1];
		end
		lock_cnt--;
	endfunction

	// Apply one request to the shadow table and return the response it should give
	function automatic lock_rsp_t apply_lock_op(input lock_req_t r);
		lock_rsp_t rs;
		logic [OFS_W:0] q1;
		logic [OFS_W:0] q2;
		bit found;
		int i;
		rs = '0;
		q1 = {1'b0, r.start};
		q2 = range_last(r.start, r.length);
		found = 0;
		case (r.opcode)
			OP_ADD: begin
				for (i = 0; i < lock_cnt; i++) begin
					if (entry_hits(i, q1, q2, 1'b1, r.caller)) found = 1;
				end
				if (found) begin
					rs.status = ST_CONFLICT;
				end else if (lock_cnt >= TBL_DEPTH) begin
					rs.status = ST_FULL;
				end else begin
					lock_tbl[lock_cnt] = '{start: r.start, length: r.length, owner: r.owner};
					lock_cnt++;
				end
			end
			OP_UNLOCK: begin
				i = 0;
				while (i < lock_cnt) begin
					if (entry_hits(i, q1, q2, 1'b0, r.caller)) begin
						drop_entry(i);
						rs.hit = 1'b1;
					end else begin
						i++;
					end
				end
			end
			OP_HOLDS: begin
				for (i = 0; i < lock_cnt; i++) begin
					if (lock_tbl[i].owner == r.owner) rs.hit = 1'b1;
				end
			end
			OP_RELEASE: begin
				i = 0;
				while (i < lock_cnt) begin
					if (lock_tbl[i].owner == r.owner) drop_entry(i);
					else i++;
				end
			end
			OP_FIND: begin
				for (i = 0; i < lock_cnt && !found; i++) begin
					if (entry_hits(i, q1, q2, r.other, r.caller)) begin
						found = 1;
						rs.hit = 1'b1;
						rs.start = lock_tbl[i].start;
						rs.length = lock_tbl[i].length;
						rs.owner = lock_tbl[i].owner;
					end
				end
			end
			default: begin
			end
		endcase
		return rs;
	endfunction

	function automatic lock_req_t mk_req(input logic [OP_W-1:0] op,
			input logic [PID_W-1:0] caller, input logic [PID_W-1:0] owner,
			input logic [OFS_W-1:0] s, input logic [OFS_W-1:0] len, input logic other);
		return '{opcode: op, caller: caller, owner: owner, start: s, length: len,
			other: other};
	endfunction

	// Clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Cycle counter and timeout
	initial begin
		cycle_cnt = 0;
		forever begin
			@(posedge clk);
			cycle_cnt++;
			if (cycle_cnt > LIMIT_CYCLES) begin
				$display("timeout after %0d cycles, %0d responses outstanding", cycle_cnt,
					pending_rsp.size());
				$display("** byte_range_lock_table_unit: FAILED **");
				$finish;
			end
		end
	end

	// Response side: random stalls plus an optional long hold-off
	initial begin
		rsp_ch.ready = 1'b0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	task automatic note_mismatch(input string fld, input logic [31:0] e,
			input logic [31:0] a);
		if (mismatch_cnt < 10) begin
			$display("mismatch at cycle %0d: %s expected %h got %h", cycle_cnt, fld, e, a);
		end
		mismatch_cnt++;
	endtask

	// Response checker
	always @(posedge clk) begin : check_rsp
		lock_rsp_t want;
		if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			if (pending_rsp.size() == 0) begin
				note_mismatch("unexpected response, status", '0, 32'(rsp_ch.status));
			end else begin
				want = pending_rsp.pop_front();
				if (rsp_ch.status !== want.status)
					note_mismatch("status", 32'(want.status), 32'(rsp_ch.status));
				if (rsp_ch.hit !== want.hit)
					note_mismatch("hit", 32'(want.hit), 32'(rsp_ch.hit));
				if (rsp_ch.match_start !== want.start)
					note_mismatch("match_start", want.start, rsp_ch.match_start);
				if (rsp_ch.match_length !== want.length)
					note_mismatch("match_length", want.length, rsp_ch.match_length);
				if (rsp_ch.match_owner !== want.owner)
					note_mismatch("match_owner", 32'(want.owner), 32'(rsp_ch.match_owner));
			end
		end
	end

	// Offer one request and wait for the transaction; called at a rising edge
	task automatic send_req(input lock_req_t r);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(0, 99) < send_idle_pct) @(posedge clk);
		end
		req_ch.valid         <= 1'b1;
		req_ch.opcode        <= r.opcode;
		req_ch.caller_pid    <= r.caller;
		req_ch.owner_pid     <= r.owner;
		req_ch.range_start   <= r.start;
		req_ch.range_length  <= r.length;
		req_ch.other_process <= r.other;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		pending_rsp = {pending_rsp, apply_lock_op(r)};
	endtask

	// Drop valid and wait for every response
	task automatic finish_sending();
		req_ch.valid <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
	endtask

	function automatic logic [PID_W-1:0] pick_pid();
		if ($urandom_range(0, 9) == 0) return PID_W'($urandom);
		return pid_pool[$urandom_range(0, 3)];
	endfunction

	function automatic logic [OFS_W-1:0] pick_start();
		int r;
		r = $urandom_range(0, 9);
		if (r < 7) return OFS_W'($urandom_range(0, 255));
		if (r == 7) return 32'hFFFF_FF00 + OFS_W'($urandom_range(0, 255));
		return $urandom;
	endfunction

	function automatic logic [OFS_W-1:0] pick_length();
		int r;
		r = $urandom_range(0, 19);
		if (r < 2) return '0;
		if (r < 12) return OFS_W'($urandom_range(1, 32));
		if (r < 16) return OFS_W'($urandom_range(33, 300));
		if (r < 18) return $urandom;
		return 32'hFFFF_FFFF - OFS_W'($urandom_range(0, 255));
	endfunction

	// Mostly lock traffic among a few processes over a small window
	function automatic lock_req_t pick_req();
		lock_req_t r;
		int w;
		w = $urandom_range(0, 99);
		if (w < 35) r.opcode = OP_ADD;
		else if (w < 50) r.opcode = OP_UNLOCK;
		else if (w < 60) r.opcode = OP_HOLDS;
		else if (w < 66) r.opcode = OP_RELEASE;
		else if (w < 95) r.opcode = OP_FIND;
		else r.opcode = OP_W'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
		r.caller = pick_pid();
		r.owner = ($urandom_range(0, 4) == 0) ? pick_pid() : r.caller;
		if (r.opcode == OP_HOLDS || r.opcode == OP_RELEASE) r.owner = pick_pid();
		r.start = pick_start();
		r.length = pick_length();
		r.other = 1'($urandom_range(0, 1));
		return r;
	endfunction

	// Every operation, enclosing entries, zero lengths and the top of the range
	task automatic test_basic_ops();
		logic [PID_W-1:0] pa;
		logic [PID_W-1:0] pb;
		logic [PID_W-1:0] pc;
		pa = 22'h000001;
		pb = 22'h2AAAAA;
		pc = 22'h155555;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		send_req(mk_req(OP_FIND, pa, pa, '0, '0, 1'b0));
		send_req(mk_req(OP_HOLDS, pa, pa, '0, '0, 1'b0));
		send_req(mk_req(OP_ADD, pa, pa, 32'd100, 32'd10, 1'b0));
		// inside an entry of another process but not touching its ends: accepted
		send_req(mk_req(OP_ADD, pb, pb, 32'd105, 32'd2, 1'b0));
		// reaches the end of pa's entry: conflict
		send_req(mk_req(OP_ADD, pb, pb, 32'd108, 32'd5, 1'b0));
		send_req(mk_req(OP_FIND, pb, pb, '0, '0, 1'b1));
		send_req(mk_req(OP_FIND, pa, pa, 32'd95, 32'd5, 1'b0));
		send_req(mk_req(OP_FIND, pc, pc, 32'd106, 32'd0, 1'b1));
		send_req(mk_req(OP_ADD, pa, pa, 32'hFFFF_FFFF, '0, 1'b0));
		send_req(mk_req(OP_ADD, pa, pa, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0));
		send_req(mk_req(OP_FIND, pc, pc, 32'hFFFF_FFF0, '0, 1'b1));
		send_req(mk_req(OP_HOLDS, pc, pb, '0, '0, 1'b0));
		send_req(mk_req(OP_HOLDS, pc, PID_ALL_ONES, '0, '0, 1'b0));
		send_req(mk_req(OP_UNLOCK, pb, pb, '0, '0, 1'b0));
		send_req(mk_req(OP_UNLOCK, pb, pb, '0, '0, 1'b0));
		for (int op = OP_UNUSED_FIRST; op <= OP_UNUSED_LAST; op++) begin
			send_req(mk_req(OP_W'(op), PID_ALL_ONES, PID_ALL_ONES, '1, '1, 1'b1));
		end
		send_req(mk_req(OP_FIND, pa, pa, '0, '0, 1'b0));
		send_req(mk_req(OP_RELEASE, pc, pa, '0, '0, 1'b0));
		send_req(mk_req(OP_HOLDS, pc, pa, '0, '0, 1'b0));
		finish_sending();
	endtask

	// Fill the table, then adds refused as full, one of them inside a stored entry
	task automatic test_table_full();
		for (int i = 0; i < TBL_DEPTH; i++) begin
			send_req(mk_req(OP_ADD, '0, PID_ALL_ONES, OFS_W'(1000 + 16 * i), 32'd4, 1'b0));
		end
		send_req(mk_req(OP_ADD, '0, '0, 32'd5000, 32'd4, 1'b0));
		send_req(mk_req(OP_ADD, '0, '0, 32'd1002, 32'd1, 1'b0));
		send_req(mk_req(OP_RELEASE, '0, PID_ALL_ONES, '0, '0, 1'b0));
		finish_sending();
	endtask

	task automatic test_random_traffic(input int n, input int idle_pct, input int stall_pct);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		for (int i = 0; i < n; i++) begin
			send_req(pick_req());
		end
		finish_sending();
	endtask

	// Long receiver hold-off while requests keep coming
	task automatic test_receiver_hold_off();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_request = 400;
		for (int i = 0; i < 40; i++) begin
			send_req(pick_req());
		end
		finish_sending();
	endtask

	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.opcode = OP_FIND;
		req_ch.caller_pid = '0;
		req_ch.owner_pid = '0;
		req_ch.range_start = '0;
		req_ch.range_length = '0;
		req_ch.other_process = 1'b0;
		mismatch_cnt = 0;
		lock_cnt = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_request = 0;
		pid_pool[0] = '0;
		pid_pool[1] = PID_ALL_ONES;
		pid_pool[2] = PID_W'($urandom);
		pid_pool[3] = PID_W'($urandom);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_ops();
		test_table_full();
		test_random_traffic(300, 0, 0);
		test_random_traffic(250, 74, 0);
		test_random_traffic(250, 0, 74);
		test_random_traffic(250, 33, 33);
		test_receiver_hold_off();
		test_random_traffic(220, 0, 0);

		finish_sending();
		repeat (TBL_DEPTH + 20) @(posedge clk);
		if (mismatch_cnt == 0 && pending_rsp.size() == 0) begin
			$display("** byte_range_lock_table_unit: PASSED **");
		end else begin
			$display("** byte_range_lock_table_unit: FAILED **");
		end
		$finish;
	end

endmodule
